/* hdl/rcpg_pkg.sv */
// shared types and constants for the raster am carrier pattern generator
package rcpg_pkg;

   localparam int PHASE_BITS = 32;
   localparam int COUNT_BITS = 12;
   localparam int REG_BITS   = 12;
   localparam int WORD_BITS  = 32;
   localparam int CSR_ADDR_BITS = 3;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_CARRIER_INC = 3'd0,
      CSR_TONE_INC    = 3'd1,
      CSR_LINE_TOTAL  = 3'd2,
      CSR_ACTIVE_W    = 3'd3,
      CSR_ACTIVE_L    = 3'd4,
      CSR_FG_COLOR    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] carrier_increment;
      logic [WORD_BITS-1:0] tone_increment;
      logic [REG_BITS-1:0]  line_total;
      logic [REG_BITS-1:0]  active_width;
      logic [REG_BITS-1:0]  active_lines;
      logic [WORD_BITS-1:0] fg_color;
   } config_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] pixel_color;
      logic                 visible;
      logic                 frame_end;
   } result_type;

endpackage

/* hdl/raster_am_carrier_pattern_gen_unit.sv */
// top level of the raster am carrier pattern generator with register file and output buffer
//
// one request is one pixel-clock tick of a raster line, blanking included, and
// yields one response with that tick's colour. a request is taken every cycle
// (req_tready stays high unless two responses are already held); the response
// appears from an output register. the pattern is set by two 32-bit phase
// accumulators that count pixel time from frame start: at the first tick of
// each line the tone phase top bit decides whether the whole line is dark, and
// on visible pixels of a lit line the carrier phase top bit selects fg_color or
// black. after active_lines lines the frame ends (rsp_tlast), and the phases
// and counters restart; req_tdata bit 0 (restart) does the same before the
// tick. the user must write registers through csr_we/csr_addr/csr_wdata only
// while the block is idle; the block itself does not enforce this. line_total
// and active_lines of zero act as one; an active_width above line_total is clamped.
module raster_am_carrier_pattern_gen_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] restart, [7:1] zero
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] pixel_color
   output logic        rsp_tuser,   // [0] visible
   output logic        rsp_tlast,   // frame_end
   // register write port
   input  logic        csr_we,
   input  logic [rcpg_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [31:0] csr_wdata
);

   rcpg_pkg::config_type cfg_ff;
   rcpg_pkg::result_type result;
   rcpg_pkg::result_type out_ff, out_in;
   rcpg_pkg::result_type skid_ff, skid_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   logic                 accept, out_free;

   // register file, reset values match the documented defaults
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.carrier_increment <= '0;
         cfg_ff.tone_increment    <= '0;
         cfg_ff.line_total        <= rcpg_pkg::REG_BITS'(1);
         cfg_ff.active_width      <= '0;
         cfg_ff.active_lines      <= rcpg_pkg::REG_BITS'(1);
         cfg_ff.fg_color          <= '1;
      end else if (csr_we) begin
         unique case (csr_addr)
            rcpg_pkg::CSR_CARRIER_INC: cfg_ff.carrier_increment <= csr_wdata;
            rcpg_pkg::CSR_TONE_INC:    cfg_ff.tone_increment    <= csr_wdata;
            rcpg_pkg::CSR_LINE_TOTAL:
               cfg_ff.line_total   <= csr_wdata[rcpg_pkg::REG_BITS-1:0];
            rcpg_pkg::CSR_ACTIVE_W:
               cfg_ff.active_width <= csr_wdata[rcpg_pkg::REG_BITS-1:0];
            rcpg_pkg::CSR_ACTIVE_L:
               cfg_ff.active_lines <= csr_wdata[rcpg_pkg::REG_BITS-1:0];
            rcpg_pkg::CSR_FG_COLOR:    cfg_ff.fg_color          <= csr_wdata;
            default: ;  // unused indexes are ignored
         endcase
      end
   end

   // a request is taken whenever the skid slot is empty
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;

   rcpg_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .step    (accept),
      .restart (req_tdata[0]),
      .result  (result)
   );

   // output register with one skid entry behind it
   always_comb begin
      out_free      = !out_valid_ff || rsp_tready;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = result;
            out_valid_in = accept;
         end
      end else if (accept) begin
         // response stalled: park the new one
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.pixel_color;
   assign rsp_tuser  = out_ff.visible;
   assign rsp_tlast  = out_ff.frame_end;

endmodule

/* hdl/rcpg_core.sv */
// raster timing counters, phase accumulators and pixel colour decision
module rcpg_core (
   input  logic                 clock,
   input  logic                 reset,
   input  rcpg_pkg::config_type cfg,
   input  logic                 step,
   input  logic                 restart,
   output rcpg_pkg::result_type result
);

   localparam int PB = rcpg_pkg::PHASE_BITS;
   localparam int CB = rcpg_pkg::COUNT_BITS;

   logic [PB-1:0] carrier_phase_ff, carrier_phase_in;
   logic [PB-1:0] tone_phase_ff, tone_phase_in;
   logic [CB-1:0] column_ff, column_in;
   logic [CB-1:0] line_ff, line_in;
   logic          line_dark_ff, line_dark_in;

   logic [PB-1:0] carrier_cur, tone_cur;
   logic [CB-1:0] column_cur, line_cur;
   logic [CB-1:0] total, lines, width;
   logic          dark, vis, last_col, fend;

   always_comb begin
      // zero totals act as one, active width clamps to the line total
      total = (cfg.line_total == '0) ? CB'(1) : CB'(cfg.line_total);
      lines = (cfg.active_lines == '0) ? CB'(1) : CB'(cfg.active_lines);
      width = (CB'(cfg.active_width) < total) ? CB'(cfg.active_width) : total;

      // restart clears the frame before this tick is evaluated
      carrier_cur = restart ? '0 : carrier_phase_ff;
      tone_cur    = restart ? '0 : tone_phase_ff;
      column_cur  = restart ? '0 : column_ff;
      line_cur    = restart ? '0 : line_ff;

      dark = (column_cur == '0) ? tone_cur[PB-1] : line_dark_ff;
      vis  = column_cur < width;

      // one extra bit so a wrapped counter still reads as past the end
      last_col = ({1'b0, column_cur} + (CB+1)'(1)) >= {1'b0, total};
      fend     = last_col && (({1'b0, line_cur} + (CB+1)'(1)) >= {1'b0, lines});

      result.pixel_color = (vis && !dark && carrier_cur[PB-1]) ? cfg.fg_color : '0;
      result.visible     = vis;
      result.frame_end   = fend;

      carrier_phase_in = carrier_cur + PB'(cfg.carrier_increment);
      tone_phase_in    = tone_cur + PB'(cfg.tone_increment);
      line_dark_in     = dark;
      if (fend) begin
         carrier_phase_in = '0;
         tone_phase_in    = '0;
         column_in        = '0;
         line_in          = '0;
      end else if (last_col) begin
         column_in = '0;
         line_in   = line_cur + CB'(1);
      end else begin
         column_in = column_cur + CB'(1);
         line_in   = line_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carrier_phase_ff <= '0;
         tone_phase_ff    <= '0;
         column_ff        <= '0;
         line_ff          <= '0;
         line_dark_ff     <= 1'b0;
      end else if (step) begin
         carrier_phase_ff <= carrier_phase_in;
         tone_phase_ff    <= tone_phase_in;
         column_ff        <= column_in;
         line_ff          <= line_in;
         line_dark_ff     <= line_dark_in;
      end
   end

endmodule
